// File: rtl/core/ihik_pkg.sv
// package: types, constants and state codes for the indexed max-heap core
package ihik_pkg;

   localparam int CAPACITY  = 256;
   localparam int KEY_BITS  = 32;
   localparam int ID_BITS   = 8;
   localparam int SLOT_BITS = 9;
   localparam int CNT_BITS  = 9;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_LOAD  = 2'd1,
      FUNC_POP   = 2'd2,
      FUNC_INC   = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_REMOVED = 2'd1,
      ST_NOT_GT  = 2'd2,
      ST_ERROR   = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]          func;
      logic [ID_BITS-1:0]  elem_id;
      logic signed [31:0]  key;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  top_key;
      logic [ID_BITS-1:0]  top_id;
      logic [CNT_BITS-1:0] count;
      logic                is_empty;
      logic [1:0]          status;
   } rsp_type;

   // slot memory word: key and owning id
   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic [ID_BITS-1:0]         owner;
   } slot_type;

   localparam int SLOT_W = KEY_BITS + ID_BITS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INC_RD,    // read owner_slot of id
      S_INC_CHK,   // read slot at position
      S_INC_CMP,   // compare key
      S_UP_RD,     // read parent
      S_UP_CMP,    // compare/swap with parent
      S_POP_RD,    // read last slot
      S_POP_WR,    // move last into root
      S_DN_RDL,    // read left child
      S_DN_RDR,    // read right child
      S_DN_CMP,    // pick child, compare, swap
      S_TOP_RD,    // read root for result
      S_RESP
   } state_type;

endpackage

// File: rtl/core/indexed_max_heap_increase_key_core.sv
// top level: indexed binary max-heap with increase-key over slot memories
//
//  channel | direction | payload  | handshake
//  req     | in        | req_type | req_valid / req_ready
//  rsp     | out       | rsp_type | rsp_valid / rsp_ready
//
// one request at a time; a load writes the new item to the last slot and
// climbs, an increase first reads the id's slot and compares the key, then
// climbs the same way, and a pop moves the last slot into the root and
// descends, up to 8 levels; each level climbed is a parent read and a compare
// with one slot write-back, each level descended reads both children before
// the compare, as the slot memory has a single port
// synchronous reset clears counts and control; memories are not cleared
// a finished result waits in the response register while the next request is
// taken; that request holds in its final state until the register is free
module indexed_max_heap_increase_key_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ihik_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ihik_pkg::rsp_type   rsp_data
);
   import ihik_pkg::*;

   // slot memory (index = slot - 1) and id -> slot map
   logic                 sm_we;
   logic [ID_BITS-1:0]   sm_addr;
   slot_type             sm_wdata, sm_rdata;
   logic                 om_we;
   logic [ID_BITS-1:0]   om_addr;
   logic [SLOT_BITS-1:0] om_wdata, om_rdata;

   ihik_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slot_ram (
      .clock(clock), .we(sm_we), .addr(sm_addr), .wdata(sm_wdata), .rdata(sm_rdata));
   ihik_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_owner_ram (
      .clock(clock), .we(om_we), .addr(om_addr), .wdata(om_wdata), .rdata(om_rdata));

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  hcnt_ff, hcnt_in, lcnt_ff, lcnt_in;
   req_type              req_ff, req_in;
   logic [SLOT_BITS-1:0] pos_ff, pos_in;   // current slot (1-based)
   slot_type             cur_ff, cur_in;   // item being sifted
   slot_type             lch_ff, lch_in;   // left child held
   logic [1:0]           st_ff, st_in;
   rsp_type              rsp_ff, rsp_in;
   logic                 rv_ff, rv_in;
   // second write of a swap: owner map entry of the sifted item
   logic                 pend_ff, pend_in;
   logic [ID_BITS-1:0]   pid_ff, pid_in;
   logic [SLOT_BITS-1:0] pslot_ff, pslot_in;

   logic [SLOT_BITS-1:0] par, lpos, rpos;
   logic                 take;

   assign par  = pos_ff >> 1;
   assign lpos = {pos_ff[SLOT_BITS-2:0], 1'b0};
   assign rpos = {pos_ff[SLOT_BITS-2:0], 1'b1};
   assign req_ready = (state_ff == S_IDLE);
   assign take = req_valid && req_ready;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   function automatic logic [ID_BITS-1:0] sidx(input logic [SLOT_BITS-1:0] s);
      logic [SLOT_BITS-1:0] t;
      t = s - SLOT_BITS'(1);
      return t[ID_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hcnt_ff  <= '0;
         lcnt_ff  <= '0;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         hcnt_ff  <= hcnt_in;
         lcnt_ff  <= lcnt_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
      end
      req_ff   <= req_in;
      pos_ff   <= pos_in;
      cur_ff   <= cur_in;
      lch_ff   <= lch_in;
      st_ff    <= st_in;
      rsp_ff   <= rsp_in;
      pid_ff   <= pid_in;
      pslot_ff <= pslot_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               unique case (func_type'(req_data.func))
                  FUNC_CLEAR: state_in = S_RESP;
                  FUNC_LOAD: begin
                     if (lcnt_ff >= CNT_BITS'(CAPACITY) || hcnt_ff >= CNT_BITS'(CAPACITY))
                        state_in = S_TOP_RD;
                     else
                        state_in = S_UP_RD;
                  end
                  FUNC_POP:   state_in = (hcnt_ff == '0) ? S_RESP : S_POP_RD;
                  FUNC_INC: begin
                     if (CNT_BITS'(req_data.elem_id) >= lcnt_ff) state_in = S_TOP_RD;
                     else state_in = S_INC_RD;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INC_RD: state_in = S_INC_CHK;
         S_INC_CHK: begin
            if (om_rdata == '0 || CNT_BITS'(om_rdata) > hcnt_ff) state_in = S_TOP_RD;
            else state_in = S_INC_CMP;
         end
         S_INC_CMP: state_in = (req_ff.key > sm_rdata.key) ? S_UP_RD : S_TOP_RD;
         S_UP_RD:   state_in = (pos_ff > SLOT_BITS'(1)) ? S_UP_CMP : S_TOP_RD;
         S_UP_CMP:  state_in = (cur_ff.key > sm_rdata.key) ? S_UP_RD : S_TOP_RD;
         S_POP_RD:  state_in = S_POP_WR;
         S_POP_WR:  state_in = S_DN_RDL;
         S_DN_RDL:  state_in = (CNT_BITS'(lpos) > hcnt_ff) ? S_TOP_RD : S_DN_RDR;
         S_DN_RDR:  state_in = S_DN_CMP;
         S_DN_CMP: begin
            if (CNT_BITS'(rpos) <= hcnt_ff && !(lch_ff.key > sm_rdata.key)) begin
               state_in = (sm_rdata.key > cur_ff.key) ? S_DN_RDL : S_TOP_RD;
            end else begin
               state_in = (lch_ff.key > cur_ff.key) ? S_DN_RDL : S_TOP_RD;
            end
         end
         S_TOP_RD:  state_in = S_RESP;
         // hold the result until the response register is free
         S_RESP:    state_in = (rv_ff && !rsp_ready) ? S_RESP : S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      slot_type ch;
      logic [SLOT_BITS-1:0] cpos;
      logic [SLOT_BITS-1:0] last;
      hcnt_in  = hcnt_ff;
      lcnt_in  = lcnt_ff;
      req_in   = req_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      lch_in   = lch_ff;
      st_in    = st_ff;
      rsp_in   = rsp_ff;
      rv_in    = rv_ff;
      pend_in  = 1'b0;
      pid_in   = pid_ff;
      pslot_in = pslot_ff;
      sm_we    = 1'b0;
      sm_addr  = '0;
      sm_wdata = cur_ff;
      om_we    = 1'b0;
      om_addr  = '0;
      om_wdata = pos_ff;
      ch       = lch_ff;
      cpos     = lpos;
      last     = SLOT_BITS'(hcnt_ff);

      if (rv_ff && rsp_ready) rv_in = 1'b0;

      // finish the owner update of the sifted item when the port is free
      if (pend_ff) begin
         om_we    = 1'b1;
         om_addr  = pid_ff;
         om_wdata = pslot_ff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               req_in = req_data;
               st_in  = ST_DONE;
               unique case (func_type'(req_data.func))
                  FUNC_CLEAR: begin
                     hcnt_in = '0;
                     lcnt_in = '0;
                  end
                  FUNC_LOAD: begin
                     if (lcnt_ff >= CNT_BITS'(CAPACITY) || hcnt_ff >= CNT_BITS'(CAPACITY)) begin
                        st_in = ST_ERROR;
                     end else begin
                        hcnt_in  = hcnt_ff + CNT_BITS'(1);
                        lcnt_in  = lcnt_ff + CNT_BITS'(1);
                        pos_in   = SLOT_BITS'(hcnt_ff) + SLOT_BITS'(1);
                        cur_in   = '{key: req_data.key, owner: lcnt_ff[ID_BITS-1:0]};
                        sm_we    = 1'b1;
                        sm_addr  = hcnt_ff[ID_BITS-1:0];
                        sm_wdata = '{key: req_data.key, owner: lcnt_ff[ID_BITS-1:0]};
                        om_we    = 1'b1;
                        om_addr  = lcnt_ff[ID_BITS-1:0];
                        om_wdata = SLOT_BITS'(hcnt_ff) + SLOT_BITS'(1);
                     end
                  end
                  FUNC_POP: begin
                     if (hcnt_ff == '0) st_in = ST_ERROR;
                     sm_addr = '0;
                  end
                  FUNC_INC: begin
                     if (CNT_BITS'(req_data.elem_id) >= lcnt_ff) st_in = ST_ERROR;
                  end
                  default: ;
               endcase
            end
         end
         S_INC_RD: om_addr = req_ff.elem_id;
         S_INC_CHK: begin
            pos_in  = om_rdata;
            sm_addr = sidx(om_rdata);
            if (om_rdata == '0 || CNT_BITS'(om_rdata) > hcnt_ff) st_in = ST_REMOVED;
         end
         S_INC_CMP: begin
            if (req_ff.key > sm_rdata.key) begin
               cur_in   = '{key: req_ff.key, owner: sm_rdata.owner};
               sm_we    = 1'b1;
               sm_addr  = sidx(pos_ff);
               sm_wdata = '{key: req_ff.key, owner: sm_rdata.owner};
            end else begin
               st_in = ST_NOT_GT;
            end
         end
         S_UP_RD: begin
            if (pos_ff > SLOT_BITS'(1)) begin
               sm_addr = sidx(par);
            end else begin
               // reached the root: the item lands in slot 1
               sm_we   = 1'b1;
               sm_addr = sidx(pos_ff);
            end
         end
         S_UP_CMP: begin
            if (cur_ff.key > sm_rdata.key) begin
               // parent moves down into pos, item moves into parent
               sm_we    = 1'b1;
               sm_addr  = sidx(pos_ff);
               sm_wdata = sm_rdata;
               om_we    = 1'b1;
               om_addr  = sm_rdata.owner;
               om_wdata = pos_ff;
               pend_in  = 1'b1;
               pid_in   = cur_ff.owner;
               pslot_in = par;
               pos_in   = par;
            end else begin
               sm_we    = 1'b1;
               sm_addr  = sidx(pos_ff);
               sm_wdata = cur_ff;
            end
         end
         S_POP_RD: begin
            // root is on the read port now; drop its id, fetch the last slot
            om_we    = 1'b1;
            om_addr  = sm_rdata.owner;
            om_wdata = '0;
            sm_addr  = sidx(last);
            hcnt_in  = hcnt_ff - CNT_BITS'(1);
            pos_in   = SLOT_BITS'(1);
         end
         S_POP_WR: begin
            cur_in = sm_rdata;
            if (hcnt_ff != '0) begin
               sm_we    = 1'b1;
               sm_addr  = '0;
               sm_wdata = sm_rdata;
               om_we    = 1'b1;
               om_addr  = sm_rdata.owner;
               om_wdata = SLOT_BITS'(1);
            end
         end
         S_DN_RDL: begin
            if (CNT_BITS'(lpos) > hcnt_ff) begin
               // no children left: the item settles here
               sm_we   = 1'b1;
               sm_addr = sidx(pos_ff);
            end else begin
               sm_addr = sidx(lpos);
            end
         end
         S_DN_RDR: begin
            lch_in  = sm_rdata;
            sm_addr = sidx(rpos);
         end
         S_DN_CMP: begin
            if (CNT_BITS'(rpos) <= hcnt_ff && !(lch_ff.key > sm_rdata.key)) begin
               ch   = sm_rdata;
               cpos = rpos;
            end
            if (ch.key > cur_ff.key) begin
               sm_we    = 1'b1;
               sm_addr  = sidx(pos_ff);
               sm_wdata = ch;
               om_we    = 1'b1;
               om_addr  = ch.owner;
               om_wdata = pos_ff;
               pend_in  = 1'b1;
               pid_in   = cur_ff.owner;
               pslot_in = cpos;
               pos_in   = cpos;
            end else begin
               sm_we    = 1'b1;
               sm_addr  = sidx(pos_ff);
               sm_wdata = cur_ff;
            end
         end
         S_TOP_RD: sm_addr = '0;
         S_RESP: begin
            // root stays on the read port while the result waits
            if (!rv_ff || rsp_ready) begin
               rv_in           = 1'b1;
               rsp_in.count    = hcnt_ff;
               rsp_in.status   = st_ff;
               rsp_in.is_empty = (hcnt_ff == '0);
               rsp_in.top_key  = (hcnt_ff == '0) ? '0 : sm_rdata.key;
               rsp_in.top_id   = (hcnt_ff == '0) ? '0 : sm_rdata.owner;
            end
         end
         default: ;
      endcase
   end
endmodule

// File: rtl/core/ihik_ram.sv
// generic single-port ram with registered read
module ihik_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
